// File: rtl/ufej_pkg.sv
// shared types, constants and helpers of the union-find edge joiner
package ufej_pkg;

	localparam int GRID_ROWS_DEF = 32;
	localparam int GRID_COLS_DEF = 32;
	localparam int COORD_W       = 5;
	localparam int RANK_W        = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	typedef struct packed {
		logic               joined;
		logic [COORD_W-1:0] wall_row;
		logic [COORD_W-1:0] wall_col;
	} ufej_res_t;

	// flatten a grid position to a table index
	function automatic int cell_index(int row, int col, int cols);
		return row * cols + col;
	endfunction

	// midpoint of two coordinates, rounded down
	function automatic logic [COORD_W-1:0] coord_mid(logic [COORD_W-1:0] a,
		logic [COORD_W-1:0] b);
		logic [COORD_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[COORD_W:1];
	endfunction

endpackage

// File: rtl/ufej_ram.sv
// single write port, single registered read port memory
module ufej_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/ufej_ctrl.sv
// sequencer: clearing pass, root walks, path compression and union by rank
module ufej_ctrl import ufej_pkg::*; #(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COORD_W-1:0] first_row,
	input  logic [COORD_W-1:0] first_col,
	input  logic [COORD_W-1:0] second_row,
	input  logic [COORD_W-1:0] second_col,
	output logic               res_valid,
	input  logic               res_free,
	output ufej_res_t          res
);

	localparam int CELLS  = GRID_ROWS * GRID_COLS;
	localparam int CELL_W = $clog2(CELLS);
	localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);
	localparam logic [8:0] ROWS_LIM = 9'(GRID_ROWS);
	localparam logic [8:0] COLS_LIM = 9'(GRID_COLS);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_IDX    = 4'd2;
	localparam logic [3:0] ST_FSTEP  = 4'd3;
	localparam logic [3:0] ST_CISSUE = 4'd4;
	localparam logic [3:0] ST_CSTEP  = 4'd5;
	localparam logic [3:0] ST_RANKA  = 4'd6;
	localparam logic [3:0] ST_RANKB  = 4'd7;
	localparam logic [3:0] ST_MERGE  = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0]         state_q;
	logic [CELL_W-1:0]  clr_q;
	logic               side_q;
	logic [COORD_W-1:0] r1_q, c1_q, r2_q, c2_q;
	logic [CELL_W-1:0]  top_q, walk_q, root_q, root_a_q;
	logic [RANK_W-1:0]  rank_a_q;
	ufej_res_t          res_q;

	logic               in_range;
	logic [CELL_W-1:0]  cell_now;
	logic [CELL_W-1:0]  cmp_a, cmp_b;
	logic               cmp_eq;
	logic               a_lt_b, rank_tie;

	logic               p_we;
	logic [CELL_W-1:0]  p_waddr, p_wdata, p_raddr, par_rd;
	logic               r_we;
	logic [CELL_W-1:0]  r_waddr, r_raddr;
	logic [RANK_W-1:0]  r_wdata, rank_rd;

	ufej_ram #(.DEPTH(CELLS), .AW(CELL_W), .DW(CELL_W)) u_parent (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (par_rd)
	);

	ufej_ram #(.DEPTH(CELLS), .AW(CELL_W), .DW(RANK_W)) u_rank (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr (r_raddr),
		.rdata (rank_rd)
	);

	assign in_range = ({4'b0, first_row} < ROWS_LIM) && ({4'b0, second_row} < ROWS_LIM) &&
		({4'b0, first_col} < COLS_LIM) && ({4'b0, second_col} < COLS_LIM);

	assign cell_now = side_q ?
		CELL_W'(cell_index(int'(r2_q), int'(c2_q), GRID_COLS)) :
		CELL_W'(cell_index(int'(r1_q), int'(c1_q), GRID_COLS));

	// one comparator serves the root walk and the compression walk
	always_comb begin
		unique case (state_q)
			ST_FSTEP:  begin cmp_a = par_rd; cmp_b = top_q;  end
			ST_CISSUE: begin cmp_a = walk_q; cmp_b = root_q; end
			default:   begin cmp_a = par_rd; cmp_b = root_q; end
		endcase
	end
	assign cmp_eq = (cmp_a == cmp_b);

	// rank of second root arrives from the table during merge
	assign a_lt_b   = (rank_a_q < rank_rd);
	assign rank_tie = (rank_a_q == rank_rd);

	always_comb begin
		p_we    = 1'b0;
		p_waddr = walk_q;
		p_wdata = root_q;
		p_raddr = par_rd;
		r_we    = 1'b0;
		r_waddr = root_a_q;
		r_wdata = rank_a_q + RANK_W'(1);
		r_raddr = root_a_q;
		unique case (state_q)
			ST_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				r_we    = 1'b1;
				r_waddr = clr_q;
				r_wdata = '0;
			end
			ST_IDX:    p_raddr = cell_now;
			ST_CISSUE: p_raddr = walk_q;
			ST_CSTEP:  p_we = 1'b1;
			ST_RANKB:  r_raddr = root_q;
			ST_MERGE: begin
				p_we = 1'b1;
				if (a_lt_b) begin
					p_waddr = root_a_q;
					p_wdata = root_q;
				end else begin
					p_waddr = root_q;
					p_wdata = root_a_q;
				end
				r_we = rank_tie && (rank_a_q != RANK_MAX);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CELL_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						r1_q   <= first_row;
						c1_q   <= first_col;
						r2_q   <= second_row;
						c2_q   <= second_col;
						side_q <= 1'b0;
						if (in_range) begin
							state_q <= ST_IDX;
						end else begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_IDX: begin
					top_q   <= cell_now;
					walk_q  <= cell_now;
					state_q <= ST_FSTEP;
				end
				ST_FSTEP: begin
					if (cmp_eq) begin
						root_q  <= top_q;
						state_q <= ST_CISSUE;
					end else begin
						top_q <= par_rd;
					end
				end
				ST_CISSUE, ST_CSTEP: begin
					if (cmp_eq) begin
						if (!side_q) begin
							root_a_q <= root_q;
							side_q   <= 1'b1;
							state_q  <= ST_IDX;
						end else if (root_q == root_a_q) begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RANKA;
						end
					end else if (state_q == ST_CSTEP) begin
						walk_q <= par_rd;
					end else begin
						state_q <= ST_CSTEP;
					end
				end
				ST_RANKA: state_q <= ST_RANKB;
				ST_RANKB: begin
					rank_a_q <= rank_rd;
					state_q  <= ST_MERGE;
				end
				ST_MERGE: begin
					res_q.joined   <= 1'b1;
					res_q.wall_row <= coord_mid(r1_q, r2_q);
					res_q.wall_col <= coord_mid(c1_q, c2_q);
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	a_merge_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (root_a_q != root_q))
		else $error("merge of a root with itself");

	a_compress_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CSTEP && !cmp_eq) |-> (par_rd != walk_q))
		else $error("compression reads the entry it writes");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("clearing pass restarted without reset");

	a_rank_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(r_we && state_q == ST_MERGE) |-> (rank_a_q != RANK_MAX))
		else $error("rank raised past its limit");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_IDX || state_q == ST_DONE))
		else $error("accepted word did not start work");
`endif

endmodule

// File: rtl/union_find_edge_joiner_top.sv
// Union-find edge joiner: takes an edge between two grid cells, finds both set roots with
// path compression in one parent table, merges by rank and reports the wall cell between
// them. After reset a clearing pass over all GRID_ROWS * GRID_COLS cells initializes the
// parent and rank tables; no word is taken meanwhile. The parent table is read once per hop
// of each cell's root walk and once per hop of its compression; union by rank keeps each
// tree depth at most log2 of the cell count. An edge with a cell outside the grid skips both
// walks and gives a result that is not joined. A stalled output holds the joiner only while
// the previous result still waits. The result sits in an output register, so a new word is
// taken while a finished result still waits.
module union_find_edge_joiner_top import ufej_pkg::*; #(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COORD_W-1:0] first_row,
	input  logic [COORD_W-1:0] first_col,
	input  logic [COORD_W-1:0] second_row,
	input  logic [COORD_W-1:0] second_col,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               joined,
	output logic [COORD_W-1:0] wall_row,
	output logic [COORD_W-1:0] wall_col
);

	logic      res_valid;
	logic      res_free;
	ufej_res_t res;
	logic      out_valid_q;
	ufej_res_t out_q;

	ufej_ctrl #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_row  (first_row),
		.first_col  (first_col),
		.second_row (second_row),
		.second_col (second_col),
		.res_valid  (res_valid),
		.res_free   (res_free),
		.res        (res)
	);

	// output slot frees up when empty or taken this cycle
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign joined    = out_q.joined;
	assign wall_row  = out_q.wall_row;
	assign wall_col  = out_q.wall_col;

endmodule

// File: verif/union_find_edge_joiner_top_test.sv
// self-checking testbench of the union-find edge joiner: grid edges in, join results checked
`timescale 1ns / 1ps

module union_find_edge_joiner_top_test;
	import ufej_pkg::*;

	localparam int CELLS       = GRID_ROWS_DEF * GRID_COLS_DEF;
	localparam int CELL_W      = $clog2(CELLS);
	localparam int IDLE_LIMIT  = 20000;
	localparam int RANDOM_WORDS = 2000;
	localparam int PRINT_CAP   = 50;

	typedef struct {
		logic [COORD_W-1:0] r1;
		logic [COORD_W-1:0] c1;
		logic [COORD_W-1:0] r2;
		logic [COORD_W-1:0] c2;
	} cell_pair_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [COORD_W-1:0] first_row = '0;
	logic [COORD_W-1:0] first_col = '0;
	logic [COORD_W-1:0] second_row = '0;
	logic [COORD_W-1:0] second_col = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               joined;
	logic [COORD_W-1:0] wall_row;
	logic [COORD_W-1:0] wall_col;

	union_find_edge_joiner_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_row  (first_row),
		.first_col  (first_col),
		.second_row (second_row),
		.second_col (second_col),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.joined     (joined),
		.wall_row   (wall_row),
		.wall_col   (wall_col)
	);

	// own copy of the disjoint-set tables
	logic [CELL_W-1:0] parent_tab [CELLS];
	logic [RANK_W-1:0] rank_tab [CELLS];

	cell_pair_t pending_words [$];
	ufej_res_t  expected_joins [$];

	int  mismatch_count = 0;
	int  words_in = 0;
	int  results_out = 0;
	int  joins_seen = 0;
	int  idle_cycles = 0;
	int  in_gap = 0;
	int  out_hold = 0;
	int  words_sent = 0;
	bit  in_taken = 1'b0;
	bit  in_calm = 1'b0;
	bit  out_calm = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// root walk, then point every entry on the walk straight at the root
	function automatic int find_root(int start);
		int top;
		int walk;
		int up;
		int hops;
		top = start;
		hops = 0;
		while (int'(parent_tab[top]) != top && hops < CELLS) begin
			top = int'(parent_tab[top]);
			hops++;
		end
		walk = start;
		hops = 0;
		while (walk != top && hops < CELLS) begin
			up = int'(parent_tab[walk]);
			parent_tab[walk] = CELL_W'(top);
			walk = up;
			hops++;
		end
		return top;
	endfunction

	function automatic ufej_res_t join_cells(cell_pair_t p);
		ufej_res_t res;
		int a;
		int b;
		res = '0;
		if (int'(p.r1) >= GRID_ROWS_DEF || int'(p.r2) >= GRID_ROWS_DEF ||
			int'(p.c1) >= GRID_COLS_DEF || int'(p.c2) >= GRID_COLS_DEF)
			return res;
		a = find_root(int'(p.r1) * GRID_COLS_DEF + int'(p.c1));
		b = find_root(int'(p.r2) * GRID_COLS_DEF + int'(p.c2));
		if (a == b)
			return res;
		if (rank_tab[a] > rank_tab[b]) begin
			parent_tab[b] = CELL_W'(a);
		end else if (rank_tab[a] < rank_tab[b]) begin
			parent_tab[a] = CELL_W'(b);
		end else begin
			// tie: second root under the first, rank saturates
			parent_tab[b] = CELL_W'(a);
			if (rank_tab[a] != RANK_MAX)
				rank_tab[a] = rank_tab[a] + RANK_W'(1);
		end
		res.joined   = 1'b1;
		res.wall_row = COORD_W'((int'(p.r1) + int'(p.r2)) >> 1);
		res.wall_col = COORD_W'((int'(p.c1) + int'(p.c2)) >> 1);
		return res;
	endfunction

	// mostly short gaps, a few long ones, none while calm
	function automatic int idle_len(bit calm);
		int unsigned k;
		if (calm)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 85)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_word(int r1, int c1, int r2, int c2);
		cell_pair_t p;
		p.r1 = COORD_W'(r1);
		p.c1 = COORD_W'(c1);
		p.r2 = COORD_W'(r2);
		p.c2 = COORD_W'(c2);
		pending_words.push_back(p);
	endtask

	// word driver
	always @(negedge clk) begin
		cell_pair_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				p = pending_words.pop_front();
				in_valid   <= 1'b1;
				first_row  <= p.r1;
				first_col  <= p.c1;
				second_row <= p.r2;
				second_col <= p.c2;
				words_sent++;
				if (words_sent % 100 == 0)
					in_calm = ($urandom_range(0, 3) == 0);
				in_gap = idle_len(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result-side stall
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (out_hold > 0) begin
			out_stall <= 1'b1;
			out_hold--;
		end else begin
			out_stall <= 1'b0;
			if (results_out % 150 == 149)
				out_calm = ($urandom_range(0, 3) == 0);
			out_hold = idle_len(out_calm);
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		cell_pair_t p;
		ufej_res_t  want;
		bit         moved;
		in_taken = 1'b0;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				moved = 1'b1;
				p.r1 = first_row;
				p.c1 = first_col;
				p.r2 = second_row;
				p.c2 = second_col;
				expected_joins.push_back(join_cells(p));
				words_in++;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				results_out++;
				if (expected_joins.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_joins.pop_front();
					if (want.joined)
						joins_seen++;
					if (joined !== want.joined)
						report_mismatch($sformatf("result %0d joined: got %b want %b",
							results_out, joined, want.joined));
					if (wall_row !== want.wall_row)
						report_mismatch($sformatf("result %0d wall_row: got %0d want %0d",
							results_out, wall_row, want.wall_row));
					if (wall_col !== want.wall_col)
						report_mismatch($sformatf("result %0d wall_col: got %0d want %0d",
							results_out, wall_col, want.wall_col));
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int          total;
		int unsigned k;
		int          r;
		int          c;
		int          r2;
		int          c2;
		int          lr1;
		int          lc1;
		int          lr2;
		int          lc2;

		for (int i = 0; i < CELLS; i++) begin
			parent_tab[i] = CELL_W'(i);
			rank_tab[i] = '0;
		end

		// directed: corners, same cell, same set, rank order, odd sums
		queue_word(0, 0, 0, 0);
		queue_word(0, 0, 0, 2);
		queue_word(31, 31, 31, 29);
		queue_word(31, 31, 0, 0);
		queue_word(0, 2, 31, 29);
		queue_word(31, 31, 31, 31);
		queue_word(1, 0, 0, 0);
		queue_word(0, 31, 31, 0);
		queue_word(31, 0, 0, 31);
		queue_word(5, 10, 5, 11);
		queue_word(30, 31, 31, 30);
		queue_word(31, 30, 30, 31);
		queue_word(16, 15, 15, 16);
		queue_word(0, 31, 0, 0);
		queue_word(21, 10, 10, 21);
		queue_word(10, 21, 21, 10);
		queue_word(31, 31, 31, 31);
		queue_word(15, 15, 16, 16);

		lr1 = 0; lc1 = 0; lr2 = 0; lc2 = 2;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			k = $urandom_range(0, 99);
			if (k < 70) begin
				// maze lattice edge, two cells apart, mostly on even cells
				if ($urandom_range(0, 4) == 0) begin
					r = 2 * $urandom_range(0, 15) + 1;
					c = 2 * $urandom_range(0, 15) + 1;
				end else begin
					r = 2 * $urandom_range(0, 15);
					c = 2 * $urandom_range(0, 15);
				end
				r2 = r;
				c2 = c;
				case ($urandom_range(0, 3))
					0: r2 = (r >= 2) ? r - 2 : r + 2;
					1: r2 = (r <= 29) ? r + 2 : r - 2;
					2: c2 = (c >= 2) ? c - 2 : c + 2;
					default: c2 = (c <= 29) ? c + 2 : c - 2;
				endcase
			end else if (k < 85) begin
				r  = $urandom_range(0, 31);
				c  = $urandom_range(0, 31);
				r2 = $urandom_range(0, 31);
				c2 = $urandom_range(0, 31);
			end else if (k < 92) begin
				r = $urandom_range(0, 30);
				c = $urandom_range(0, 30);
				r2 = r;
				c2 = c;
				if ($urandom_range(0, 1))
					r2 = r + 1;
				else
					c2 = c + 1;
			end else if (k < 96) begin
				r = $urandom_range(0, 31);
				c = $urandom_range(0, 31);
				r2 = r;
				c2 = c;
			end else begin
				// previous edge reversed: always the same set by now
				r = lr2; c = lc2; r2 = lr1; c2 = lc1;
			end
			if ($urandom_range(0, 1)) begin
				lr1 = r; lc1 = c; lr2 = r2; lc2 = c2;
			end else begin
				lr1 = r2; lc1 = c2; lr2 = r; lc2 = c;
			end
			queue_word(lr1, lc1, lr2, lc2);
		end
		total = pending_words.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || words_in != total)
			@(posedge clk);
		while (expected_joins.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("run covered %0d edge words and %0d result words, %0d of them joins",
			words_in, results_out, joins_seen);
		$display("edges: maze lattice, random pairs, neighbors, same cell, repeated sets");
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
